[sv/jlt_pkg.sv]
// Package for the JSON-like byte tokenizer: item types, queue entry type,
// character codes and queue sizing. No dependencies.
package jlt_pkg;

  // Input item: one byte of text plus the last-byte flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // Result item: one token byte, or an end-only mark.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
  } out_item_t;

  // Queue entry: the one or two results that one input item causes.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } res_pair_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChNul    = 8'h00;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == ChLBrack) || (c == ChRBrack) || (c == ChLBrace) ||
           (c == ChRBrace) || (c == ChColon) || (c == ChComma);
  endfunction

  // Build a result; the byte reads as zero in an end-only mark.
  function automatic out_item_t mk_res(input logic [7:0] b, input logic v, input logic e);
    out_item_t r;
    r.out_byte   = v ? b : 8'h00;
    r.byte_valid = v;
    r.token_end  = e;
    return r;
  endfunction

endpackage

[sv/jlt_front.sv]
// Front end of the tokenizer: accepts bytes, tracks lexer state and forms
// the results of each byte. Depends on jlt_pkg.
module jlt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  jlt_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               q_push,
  output jlt_pkg::res_pair_t q_data
);
  import jlt_pkg::*;

  logic       in_token, first_of_token, in_dq, in_sq, in_lc, in_bc, esc;
  logic [7:0] prev;
  logic       in_token_next, first_next, in_dq_next, in_sq_next;
  logic       in_lc_next, in_bc_next, esc_next;
  logic [7:0] prev_next;

  logic [1:0] n;
  out_item_t  r0, r1;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (n != 2'd0);
  assign q_data   = '{two: n[1], r0: r0, r1: r1};

  always_comb begin
    logic [7:0] c, t, prev_eff;
    logic       clr, first_eff;
    c         = in_item.in_byte;
    t         = c;
    prev_eff  = prev;
    first_eff = first_of_token;
    clr       = 1'b0;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    in_token_next = in_token;
    first_next    = first_of_token;
    in_dq_next    = in_dq;
    in_sq_next    = in_sq;
    in_lc_next    = in_lc;
    in_bc_next    = in_bc;
    esc_next      = esc;
    prev_next     = prev;

    if (in_lc) begin
      if (c == ChLf) begin
        r0 = mk_res(ChNul, 1'b0, 1'b1); n = 2'd1; clr = 1'b1;
      end else begin
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1; prev_next = c;
      end
    end else if (in_bc) begin
      if (prev == ChStar && c == ChSlash) begin
        r0 = mk_res(c, 1'b1, 1'b1); n = 2'd1; clr = 1'b1;
      end else begin
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1; prev_next = c;
      end
    end else if (in_dq || in_sq) begin
      if (esc) begin
        case (c)
          ChLowerN: t = ChLf;
          ChLowerR: t = ChCr;
          ChLowerT: t = ChTab;
          ChDigit0: t = ChNul;
          default:  t = c;
        endcase
        esc_next = 1'b0;
        r0 = mk_res(t, 1'b1, 1'b0); n = 2'd1; prev_next = t;
      end else if (c == ChBslash) begin
        esc_next = 1'b1;
      end else if ((in_dq && c == ChDquote) || (in_sq && c == ChSquote)) begin
        r0 = mk_res(ChNul, 1'b0, 1'b1); n = 2'd1; clr = 1'b1;
      end else begin
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1; prev_next = c;
      end
    end else if (in_token || !is_ws(c)) begin
      // a fresh token starts with no previous byte
      if (!in_token) begin
        first_eff = 1'b1;
        prev_eff  = ChNul;
      end
      in_token_next = 1'b1;
      if (prev_eff == ChSlash && (c == ChSlash || c == ChStar)) begin
        in_lc_next = (c == ChSlash);
        in_bc_next = (c == ChStar);
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1;
        prev_next = c; first_next = 1'b0;
      end else if (c == ChDquote || c == ChSquote) begin
        in_dq_next = (c == ChDquote);
        in_sq_next = (c == ChSquote);
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1;
        prev_next = c; first_next = 1'b0;
      end else if (is_ws(c)) begin
        r0 = mk_res(ChNul, 1'b0, 1'b1); n = 2'd1; clr = 1'b1;
      end else if (is_punct(c)) begin
        if (first_eff) begin
          r0 = mk_res(c, 1'b1, 1'b1); n = 2'd1;
        end else begin
          r0 = mk_res(ChNul, 1'b0, 1'b1);
          r1 = mk_res(c, 1'b1, 1'b1); n = 2'd2;
        end
        clr = 1'b1;
      end else begin
        r0 = mk_res(c, 1'b1, 1'b0); n = 2'd1;
        prev_next = c; first_next = 1'b0;
      end
    end

    if (clr) in_token_next = 1'b0;

    // end of text closes an open token
    if (in_item.end_of_input) begin
      if (in_token_next) begin
        case (n)
          2'd0: begin
            r0 = mk_res(ChNul, 1'b0, 1'b1); n = 2'd1;
          end
          2'd1: r0.token_end = 1'b1;
          default: r1.token_end = 1'b1;
        endcase
      end
      clr = 1'b1;
    end

    if (clr) begin
      in_token_next = 1'b0;
      first_next    = 1'b1;
      in_dq_next    = 1'b0;
      in_sq_next    = 1'b0;
      in_lc_next    = 1'b0;
      in_bc_next    = 1'b0;
      esc_next      = 1'b0;
      prev_next     = ChNul;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token       <= 1'b0;
      first_of_token <= 1'b1;
      in_dq          <= 1'b0;
      in_sq          <= 1'b0;
      in_lc          <= 1'b0;
      in_bc          <= 1'b0;
      esc            <= 1'b0;
      prev           <= ChNul;
    end else if (accept) begin
      in_token       <= in_token_next;
      first_of_token <= first_next;
      in_dq          <= in_dq_next;
      in_sq          <= in_sq_next;
      in_lc          <= in_lc_next;
      in_bc          <= in_bc_next;
      esc            <= esc_next;
      prev           <= prev_next;
    end
  end

endmodule

[sv/jlt_queue.sv]
// Short queue of result pairs between front and back end.
// Depends on jlt_pkg.
module jlt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jlt_pkg::res_pair_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output jlt_pkg::res_pair_t rdata
);
  import jlt_pkg::*;

  res_pair_t        slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == QCntW'(QDepth));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/jlt_back.sv]
// Back end of the tokenizer: splits queued pairs into single result items
// and holds them in the output register. Depends on jlt_pkg.
module jlt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  jlt_pkg::res_pair_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output jlt_pkg::out_item_t out_item
);
  import jlt_pkg::*;

  logic second;   // next result comes from r1 of the head pair
  logic load;

  assign load  = !out_valid || out_ready;
  assign q_pop = load && q_not_empty && (!q_data.two || second);

  always_ff @(posedge clk) begin
    if (load && q_not_empty) out_item <= second ? q_data.r1 : q_data.r0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) second <= q_data.two && !second;
    end
  end

endmodule

[sv/json_like_byte_tokenizer.sv]
// Top level of the JSON-like byte tokenizer: front end, result queue and
// back end. Depends on jlt_pkg, jlt_front, jlt_queue and jlt_back.
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_item    | into      | in_byte, end_of_input
//  out     | out_valid, out_ready, out_item | out of    | out_byte, byte_valid,
//          |                                |           | token_end
//
// One byte item is taken per cycle while the queue has room; the lexer state
//   updates in the same cycle, so there is no per-byte bubble.
// A byte yields zero, one or two result items; the back end sends one item a
//   cycle unless out stalls, so word-then-punctuation runs wait on the out port.
// A byte's first result passes through the queue, then the output register.
// Reset (rst, synchronous) empties the queue and returns the lexer to idle.
// A stall on out fills the four-entry queue, after which in_ready drops.
module json_like_byte_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  jlt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output jlt_pkg::out_item_t out_item
);
  import jlt_pkg::*;

  logic      q_full, q_push, q_pop, q_not_empty;
  res_pair_t q_wdata, q_rdata;

  // Front: classify each byte and form its result pair.
  jlt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Queue decouples byte intake from result delivery.
  jlt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // Back: one result item per cycle into the output register unless out stalls.
  jlt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

[test/jlt_token_checker.sv]
// Token checker for the JSON-like byte tokenizer: watches both channels, predicts
// the token items of every accepted byte and compares them in order.
// Depends on jlt_pkg for the item types and character codes.
`timescale 1ns / 100ps

module jlt_token_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  jlt_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  jlt_pkg::out_item_t out_item,
  output int                 n_errors,
  output int                 n_pending
);
  import jlt_pkg::*;

  // Lexer state of the predictor.
  logic       tk_open;
  logic       tk_fresh;
  logic       str_dq;
  logic       str_sq;
  logic       cmt_line;
  logic       cmt_block;
  logic       esc_armed;
  logic [7:0] last_byte;

  out_item_t token_q[$];
  out_item_t want;
  int        mismatches = 0;
  int        pending = 0;

  assign n_errors  = mismatches;
  assign n_pending = pending;

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return c == ChLBrack || c == ChRBrack || c == ChLBrace || c == ChRBrace ||
           c == ChColon || c == ChComma;
  endfunction

  function automatic out_item_t token_mark(input logic [7:0] b, input logic v, input logic e);
    out_item_t r;
    r.out_byte   = v ? b : 8'h00;
    r.byte_valid = v;
    r.token_end  = e;
    return r;
  endfunction

  task automatic lexer_clear();
    tk_open   = 1'b0;
    tk_fresh  = 1'b1;
    str_dq    = 1'b0;
    str_sq    = 1'b0;
    cmt_line  = 1'b0;
    cmt_block = 1'b0;
    esc_armed = 1'b0;
    last_byte = 8'h00;
  endtask

  // Work out the zero, one or two token items that one byte causes.
  task automatic tokenize_byte(input in_item_t it);
    logic [7:0] c;
    logic [7:0] t;
    out_item_t  res [2];
    int         n;
    c = it.in_byte;
    n = 0;
    if (cmt_line) begin
      if (c == ChLf) begin
        res[n] = token_mark(ChNul, 1'b0, 1'b1); n++;
        lexer_clear();
      end else begin
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
      end
    end else if (cmt_block) begin
      if (last_byte == ChStar && c == ChSlash) begin
        res[n] = token_mark(c, 1'b1, 1'b1); n++;
        lexer_clear();
      end else begin
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
      end
    end else if (str_dq || str_sq) begin
      if (esc_armed) begin
        case (c)
          ChLowerN: t = ChLf;
          ChLowerR: t = ChCr;
          ChLowerT: t = ChTab;
          ChDigit0: t = ChNul;
          default:  t = c;
        endcase
        esc_armed = 1'b0;
        res[n] = token_mark(t, 1'b1, 1'b0); n++;
        last_byte = t;
      end else if (c == ChBslash) begin
        esc_armed = 1'b1;
      end else if ((str_dq && c == ChDquote) || (str_sq && c == ChSquote)) begin
        res[n] = token_mark(ChNul, 1'b0, 1'b1); n++;
        lexer_clear();
      end else begin
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
      end
    end else if (tk_open || !is_blank(c)) begin
      if (!tk_open) begin
        tk_open   = 1'b1;
        tk_fresh  = 1'b1;
        last_byte = 8'h00;
      end
      if (last_byte == ChSlash && (c == ChSlash || c == ChStar)) begin
        if (c == ChSlash) cmt_line = 1'b1;
        else cmt_block = 1'b1;
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
        tk_fresh  = 1'b0;
      end else if (c == ChDquote || c == ChSquote) begin
        if (c == ChDquote) str_dq = 1'b1;
        else str_sq = 1'b1;
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
        tk_fresh  = 1'b0;
      end else if (is_blank(c)) begin
        res[n] = token_mark(ChNul, 1'b0, 1'b1); n++;
        lexer_clear();
      end else if (is_separator(c)) begin
        if (!tk_fresh) begin
          res[n] = token_mark(ChNul, 1'b0, 1'b1); n++;
        end
        res[n] = token_mark(c, 1'b1, 1'b1); n++;
        lexer_clear();
      end else begin
        res[n] = token_mark(c, 1'b1, 1'b0); n++;
        last_byte = c;
        tk_fresh  = 1'b0;
      end
    end
    // last byte of the text closes any open token and drops all state
    if (it.end_of_input) begin
      if (tk_open) begin
        if (n > 0) begin
          res[n-1].token_end = 1'b1;
        end else begin
          res[n] = token_mark(ChNul, 1'b0, 1'b1); n++;
        end
      end
      lexer_clear();
    end
    for (int i = 0; i < n; i++) token_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lexer_clear();
      token_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected item byte %02h valid %0b end %0b", $time,
                     out_item.out_byte, out_item.byte_valid, out_item.token_end);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.byte_valid !== want.byte_valid ||
              out_item.token_end !== want.token_end) begin
            if (mismatches < 10)
              $display("%0t: expected byte %02h valid %0b end %0b, got byte %02h valid %0b end %0b",
                       $time, want.out_byte, want.byte_valid, want.token_end,
                       out_item.out_byte, out_item.byte_valid, out_item.token_end);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) tokenize_byte(in_item);
    end
    pending = token_q.size();
  end

endmodule

[test/tb_json_like_byte_tokenizer.sv]
// Testbench top for json_like_byte_tokenizer: clock, reset, byte stimulus and verdict.
// Depends on jlt_pkg, the tokenizer RTL and jlt_token_checker.
`timescale 1ns / 100ps

module tb_json_like_byte_tokenizer;
  import jlt_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int n_errors;
  int n_pending;
  int pushed = 0;   // bytes sent, for the stop criterion
  bit calm = 1'b0;  // set over a stretch of documents: no idling on either side

  json_like_byte_tokenizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  jlt_token_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Sink side: stalls at random about 16 percent of the time, never while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 16);
  end

  // Offer one byte and hold it until taken. A random gap may come first; when
  // there is none, valid simply stays high into the next item.
  task automatic push_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte      = b;
    it.end_of_input = last;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pushed++;
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last && (i == s.len() - 1));
  endtask

  // Stop sending and let the tokenizer drain every outstanding item.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(5))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChLf;
      3:       return ChVt;
      4:       return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] separator_byte();
    case ($urandom_range(5))
      0:       return ChLBrack;
      1:       return ChRBrack;
      2:       return ChLBrace;
      3:       return ChRBrace;
      4:       return ChColon;
      default: return ChComma;
    endcase
  endfunction

  // Mostly letters and digits; now and then a slash, star or backslash so that
  // comment openers and stray backslashes turn up inside words.
  function automatic logic [7:0] word_byte();
    case ($urandom_range(11))
      0:       return ChSlash;
      1:       return ChStar;
      2:       return ChBslash;
      3:       return 8'h30 + 8'($urandom_range(9));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic gen_word();
    repeat ($urandom_range(6, 1)) push_byte(word_byte(), 1'b0);
  endtask

  // Quoted string with escapes, the other quote, slashes and arbitrary bytes;
  // occasionally left unclosed.
  task automatic gen_string();
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(1) ? ChDquote : ChSquote;
    push_byte(q, 1'b0);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        0, 1: begin
          push_byte(ChBslash, 1'b0);
          case ($urandom_range(7))
            0:       c = ChLowerN;
            1:       c = ChLowerR;
            2:       c = ChLowerT;
            3:       c = ChDigit0;
            4:       c = ChDquote;
            5:       c = ChSquote;
            6:       c = ChBslash;
            default: c = 8'($urandom_range(255));
          endcase
        end
        2:       c = (q == ChDquote) ? ChSquote : ChDquote;
        3:       c = ChSlash;
        4:       c = 8'($urandom_range(255));
        default: c = 8'($urandom_range(126, 32));
      endcase
      if (c == q || c == ChBslash) c = 8'h78;
      push_byte(c, 1'b0);
    end
    if ($urandom_range(9) != 0) push_byte(q, 1'b0);
  endtask

  task automatic gen_comment();
    logic line;
    line = 1'($urandom_range(1));
    push_byte(ChSlash, 1'b0);
    push_byte(line ? ChSlash : ChStar, 1'b0);
    repeat ($urandom_range(5)) push_byte(8'($urandom_range(126, 32)), 1'b0);
    if (line) begin
      push_byte(ChLf, 1'b0);
    end else begin
      push_byte(ChStar, 1'b0);
      push_byte(ChSlash, 1'b0);
    end
  endtask

  // Whitespace between tokens; it ends an open token, else the tokenizer skips it.
  task automatic gen_gap();
    int n;
    n = $urandom_range(2);
    repeat (n) push_byte(blank_byte(), 1'b0);
  endtask

  // One text: a run of tokens, some noise and broken pieces, then a last byte
  // that may land anywhere, inside a string or comment included.
  task automatic gen_document();
    int r;
    repeat ($urandom_range(12, 3)) begin
      r = $urandom_range(99);
      if (r < 30) gen_word();
      else if (r < 50) push_byte(separator_byte(), 1'b0);
      else if (r < 68) gen_string();
      else if (r < 80) gen_comment();
      else if (r < 90) push_byte(8'($urandom_range(255)), 1'b0);
      else if (r < 95) push_byte($urandom_range(1) ? ChDquote : ChSquote, 1'b0);
      else begin
        push_byte(ChSlash, 1'b0);
        push_byte(ChStar, 1'b0);
      end
      gen_gap();
    end
    case ($urandom_range(3))
      0:       push_byte(separator_byte(), 1'b1);
      1:       push_byte(blank_byte(), 1'b1);
      2:       push_byte(word_byte(), 1'b1);
      default: push_byte(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: leading space, backslash as word data, word then comma,
    // lone brace, string with newline escape, other quote, slashes and an
    // escaped quote, NUL as data, then closing quote.
    push_text(" a\\,{\"\\n'//\\\"", 1'b0);
    push_byte(ChNul, 1'b0);
    push_byte(ChDquote, 1'b0);
    // Empty block comment, word ended by a blank, line comment up to newline.
    push_text("\t/**/ z //x\n", 1'b0);
    // Text ends inside a single-quoted string with an escape armed.
    push_text("'\\", 1'b1);
    // One-byte token that is also the last byte, then a last byte outside a token.
    push_byte(8'hFF, 1'b1);
    push_byte(ChSpace, 1'b1);

    pushed = 0;
    for (int d = 0; pushed < 500; d++) begin
      calm = (d >= 6 && d < 12);
      gen_document();
      if (d == 3) drain();
    end
    calm = 1'b0;

    drain();
    repeat (16) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
